### src/vag_pkg.sv
package vag_pkg;

	// byte positions within a 16-byte block
	localparam logic [3:0] POS_HEADER = 4'd0;
	localparam logic [3:0] POS_FLAGS  = 4'd1;

	// predictor nibble values above this are taken as zero
	localparam logic [3:0] PRED_MAX = 4'd4;

	// flags byte values that are reported
	localparam logic [7:0] FLAGS_LOOP_START = 8'd6;
	localparam logic [7:0] FLAGS_LOOP_END   = 8'd3;
	localparam logic [7:0] FLAGS_END        = 8'd7;

	// reported flag codes
	localparam logic [1:0] FLAG_OTHER      = 2'd0;
	localparam logic [1:0] FLAG_LOOP_START = 2'd1;
	localparam logic [1:0] FLAG_LOOP_END   = 2'd2;
	localparam logic [1:0] FLAG_END        = 2'd3;

	// result kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 8;
	localparam int PROD_W   = SAMPLE_W + COEF_W;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic       is_status;
		logic       clear;
		logic [1:0] flag;
		logic [2:0] pred;
		logic [3:0] shift;
		logic [7:0] data;
	} vag_op_t;

	function automatic logic signed [COEF_W-1:0] coef_first(input logic [2:0] pred);
		logic signed [COEF_W-1:0] c;
		case (pred)
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_second(input logic [2:0] pred);
		logic signed [COEF_W-1:0] c;
		case (pred)
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

### src/vag_adpcm_block_decoder.sv
// SPU ADPCM block decoder. Bytes of 16-byte blocks arrive one per input
// beat on s_axis, with tuser set on the first byte of a new stream (this
// clears the sample history and the byte position; the byte is a header).
// Byte 0 of a block sets predictor and shift and gives no result; byte 1
// gives one status beat on m_axis (tuser high, tdata[17:16] the flag code);
// each of bytes 2..15 gives two sample beats, low nibble first, tlast on
// the second, unless the block carries the end flag, in which case its data
// bytes give nothing. The front side accepts one byte per cycle while the
// queue of QUEUE_DEPTH ops is not full; the back side runs one result per
// cycle while m_axis is not stalled, since each sample feeds the two-tap
// filter of the next through the history registers. A data byte gives the
// back two results, a flags byte one, header and end-block bytes none. A
// result passes through the queue and the output register to m_axis.
module vag_adpcm_block_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [15:0] sample, [17:16] block_flag, [23:18] zero
	output logic        m_axis_tuser,  // [0] kind
	output logic        m_axis_tlast
);
	import vag_pkg::*;

	// front to queue
	logic    push;
	vag_op_t push_op;
	logic    queue_full;

	// queue to back
	logic    op_valid;
	vag_op_t head_op;
	logic    pop;

	logic [SAMPLE_W-1:0] sample;
	logic [1:0]          flag;

	// byte tracking, header decode and flags classification
	vag_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_data    (s_axis_tdata),
		.in_restart (s_axis_tuser),
		.queue_full (queue_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.push_op    (push_op)
	);

	// decouples byte intake from result delivery
	vag_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (op_valid),
		.head_op   (head_op)
	);

	// filter, history and output register
	vag_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op         (head_op),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (m_axis_tuser),
		.out_sample (sample),
		.out_flag   (flag),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, flag, sample};

endmodule

### src/vag_front.sv
module vag_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_data,
	input  logic            in_restart,
	input  logic            queue_full,
	output logic            in_ready,
	output logic            push,
	output vag_pkg::vag_op_t push_op
);
	import vag_pkg::*;

	logic [3:0] pos_q;
	logic [2:0] pred_q;
	logic [3:0] shift_q;
	logic       end_q;
	logic       clear_pend_q;

	logic       accept;
	logic [3:0] pos;
	logic [1:0] flag;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign pos      = in_restart ? POS_HEADER : pos_q;

	always_comb begin
		case (in_data)
			FLAGS_LOOP_START: flag = FLAG_LOOP_START;
			FLAGS_LOOP_END:   flag = FLAG_LOOP_END;
			FLAGS_END:        flag = FLAG_END;
			default:          flag = FLAG_OTHER;
		endcase
	end

	// header bytes and end-block data bytes give no work to the back
	assign push = accept && (pos != POS_HEADER) && ((pos == POS_FLAGS) || !end_q);

	always_comb begin
		push_op.is_status = (pos == POS_FLAGS);
		push_op.clear     = clear_pend_q;
		push_op.flag      = flag;
		push_op.pred      = pred_q;
		push_op.shift     = shift_q;
		push_op.data      = in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			pred_q       <= '0;
			shift_q      <= '0;
			end_q        <= 1'b0;
			clear_pend_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos + 4'd1;
			if (pos == POS_HEADER) begin
				pred_q  <= (in_data[7:4] > PRED_MAX) ? 3'd0 : in_data[6:4];
				shift_q <= in_data[3:0];
			end
			if (pos == POS_FLAGS) begin
				end_q <= (in_data == FLAGS_END);
			end
			// history clear travels with the next op the back sees
			if (in_restart) begin
				clear_pend_q <= 1'b1;
			end else if (push) begin
				clear_pend_q <= 1'b0;
			end
		end
	end

endmodule

### src/vag_queue.sv
module vag_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vag_pkg::vag_op_t push_op,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output vag_pkg::vag_op_t head_op
);
	import vag_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	vag_op_t        mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_op   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count did not follow a write");

endmodule

### src/vag_back.sv
module vag_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  vag_pkg::vag_op_t op,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_kind,
	output logic [15:0]      out_sample,
	output logic [1:0]       out_flag,
	output logic             out_last
);
	import vag_pkg::*;

	logic                      phase_q;
	logic signed [SAMPLE_W-1:0] hist1_q;
	logic signed [SAMPLE_W-1:0] hist2_q;
	logic                      out_valid_q;
	logic                      out_kind_q;
	logic [SAMPLE_W-1:0]       out_sample_q;
	logic [1:0]                out_flag_q;
	logic                      out_last_q;

	logic                      slot_free;
	logic                      fire;
	logic                      clr;
	logic [SAMPLE_W-1:0]       h1;
	logic [SAMPLE_W-1:0]       h2;
	logic signed [COEF_W-1:0]  ca;
	logic signed [COEF_W-1:0]  cb;
	logic [PROD_W-1:0]         pa;
	logic [PROD_W-1:0]         pb;
	logic [PROD_W:0]           psum;
	logic [PROD_W-6:0]         filt;
	logic [3:0]                nib;
	logic signed [SAMPLE_W-1:0] nsh;
	logic signed [PROD_W-5:0]  vsum;
	logic [SAMPLE_W-1:0]       vclamp;

	assign slot_free = !out_valid_q || out_ready;
	assign fire      = op_valid && slot_free;
	assign pop       = fire && (op.is_status || phase_q);

	// a pending restart clears the history before the first use of the op
	assign clr = op.clear && !phase_q;
	assign h1  = clr ? '0 : hist1_q;
	assign h2  = clr ? '0 : hist2_q;
	assign ca  = coef_first(op.pred);
	assign cb  = coef_second(op.pred);

	assign pa   = {{COEF_W{h1[SAMPLE_W-1]}}, h1} * {{SAMPLE_W{ca[COEF_W-1]}}, ca};
	assign pb   = {{COEF_W{h2[SAMPLE_W-1]}}, h2} * {{SAMPLE_W{cb[COEF_W-1]}}, cb};
	assign psum = {pa[PROD_W-1], pa} + {pb[PROD_W-1], pb};
	assign filt = psum[PROD_W:6];

	assign nib  = phase_q ? op.data[7:4] : op.data[3:0];
	assign nsh  = $signed({nib, 12'b0}) >>> op.shift;
	assign vsum = $signed({filt[PROD_W-6], filt}) + $signed({{4{nsh[SAMPLE_W-1]}}, nsh});

	always_comb begin
		if (vsum > 20'sd32767) begin
			vclamp = 16'h7fff;
		end else if (vsum < -20'sd32768) begin
			vclamp = 16'h8000;
		end else begin
			vclamp = vsum[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			hist1_q     <= '0;
			hist2_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (op.is_status) begin
					phase_q <= 1'b0;
					if (op.clear) begin
						hist1_q <= '0;
						hist2_q <= '0;
					end
				end else begin
					phase_q <= !phase_q;
					hist2_q <= h1;
					hist1_q <= vclamp;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_kind_q   <= op.is_status ? KIND_STATUS : KIND_SAMPLE;
			out_sample_q <= op.is_status ? '0 : vclamp;
			out_flag_q   <= op.is_status ? op.flag : FLAG_OTHER;
			out_last_q   <= op.is_status || phase_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_sample = out_sample_q;
	assign out_flag   = out_flag_q;
	assign out_last   = out_last_q;

	a_second_half_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (op_valid && !op.is_status))
		else $error("second sample pending without a data op at the head");

	a_history_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !op.is_status) |=> (hist1_q == $past(vclamp) && hist2_q == $past(h1)))
		else $error("history did not advance with a sample");

	a_last_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_last_q == $past(pop)))
		else $error("last marker out of step with queue pop");

endmodule
